### rtl/core/assert_macros.svh
// assert_macros.svh: concurrent assertion macros for the dq current observer.
// Standalone header; no dependencies. SYNTH removes the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent true at a clock edge implies consequent at the same edge
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent true at a clock edge implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/core/dqco_pkg.sv
// dqco_pkg: widths, item structs, register indexes and datapath op codes
// shared by the dq current observer modules. No dependencies.
package dqco_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 24;
  localparam int DECAY_W   = 16;
  localparam int EST_W     = SAMPLE_W + 8;
  localparam int INT_W     = SAMPLE_W + 16;
  localparam int AXES      = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MODEL_GAIN_D = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MODEL_GAIN_Q = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_D      = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_Q      = CFG_IDX_W'(5);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] meas_current_d;
    logic signed [SAMPLE_W-1:0] meas_current_q;
    logic signed [SAMPLE_W-1:0] volt_cmd_d;
    logic signed [SAMPLE_W-1:0] volt_cmd_q;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] est_current_d;
    logic signed [SAMPLE_W-1:0] est_current_q;
    logic signed [SAMPLE_W-1:0] disturb_d;
    logic signed [SAMPLE_W-1:0] disturb_q;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_P,
    OP_MUL_I,
    OP_INTEG,
    OP_DRIVE,
    OP_MUL_M,
    OP_MUL_D,
    OP_EST,
    OP_OUT
  } op_t;

endpackage

### rtl/core/dqco_datapath.sv
// dqco_datapath: per-axis observer arithmetic, config registers and state.
// One multiplier per axis, driven step by step by op from dqco_ctrl. Uses dqco_pkg.
module dqco_datapath import dqco_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  input  in_item_t             in_data,
  input  op_t                  op,
  output out_item_t            out_data
);

  localparam int PROD_W = EST_W + GAIN_W + 1;
  localparam int T1_W   = PROD_W - 8;
  localparam int T2_W   = PROD_W - 16;
  localparam int DIST_W = INT_W + 1;
  localparam int DSH_W  = DIST_W - 16;

  function automatic logic signed [63:0] clamp(input logic signed [63:0] x, input int w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) clamp = hi;
    else if (x < lo) clamp = lo;
    else clamp = x;
  endfunction

  // configuration
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  integ_gain;
  logic [GAIN_W-1:0]  model_gain [AXES];
  logic [DECAY_W-1:0] decay      [AXES];

  // observer state
  logic signed [EST_W-1:0] est_q   [AXES];
  logic signed [INT_W-1:0] integ_q [AXES];

  // working registers
  logic signed [SAMPLE_W-1:0] e_q       [AXES];
  logic signed [SAMPLE_W-1:0] volt_q    [AXES];
  logic signed [PROD_W-1:0]   prod_q    [AXES];
  logic signed [INT_W-1:0]    p_q       [AXES];
  logic signed [SAMPLE_W-1:0] drv_q     [AXES];
  logic signed [SAMPLE_W-1:0] disturb_q [AXES];
  logic signed [T1_W-1:0]     t1_q      [AXES];

  logic signed [SAMPLE_W-1:0] meas_in     [AXES];
  logic signed [SAMPLE_W-1:0] volt_in     [AXES];
  logic signed [SAMPLE_W-1:0] e_new       [AXES];
  logic signed [EST_W-1:0]    mul_a       [AXES];
  logic        [GAIN_W-1:0]   mul_b       [AXES];
  logic signed [PROD_W-1:0]   mul_p       [AXES];
  logic signed [INT_W-1:0]    prod_sat    [AXES];
  logic signed [INT_W-1:0]    integ_sum   [AXES];
  logic signed [DIST_W-1:0]   dist_sum    [AXES];
  logic signed [DSH_W-1:0]    dsh         [AXES];
  logic signed [SAMPLE_W-1:0] disturb_new [AXES];
  logic signed [SAMPLE_W-1:0] drv_new     [AXES];
  logic signed [T2_W-1:0]     t2          [AXES];
  logic signed [EST_W-1:0]    est_new     [AXES];
  logic signed [SAMPLE_W-1:0] est_out     [AXES];

  always_comb begin
    meas_in[0] = in_data.meas_current_d;
    meas_in[1] = in_data.meas_current_q;
    volt_in[0] = in_data.volt_cmd_d;
    volt_in[1] = in_data.volt_cmd_q;
    for (int k = 0; k < AXES; k++) begin
      e_new[k] = SAMPLE_W'(clamp(64'(meas_in[k]) - 64'(est_q[k] >>> 8), SAMPLE_W));

      unique case (op)
        OP_MUL_P: begin
          mul_a[k] = EST_W'(e_q[k]);
          mul_b[k] = prop_gain;
        end
        OP_MUL_I: begin
          mul_a[k] = EST_W'(e_q[k]);
          mul_b[k] = integ_gain;
        end
        OP_MUL_M: begin
          mul_a[k] = EST_W'(drv_q[k]);
          mul_b[k] = model_gain[k];
        end
        default: begin
          mul_a[k] = est_q[k];
          mul_b[k] = GAIN_W'(decay[k]);
        end
      endcase
      mul_p[k] = PROD_W'(mul_a[k]) * PROD_W'($signed({1'b0, mul_b[k]}));

      prod_sat[k]  = INT_W'(clamp(64'(prod_q[k]), INT_W));
      integ_sum[k] = INT_W'(clamp(64'(integ_q[k]) + 64'(prod_sat[k]), INT_W));

      // floor(dist + v * 2^16) >> 16 equals (dist >> 16) + v
      dist_sum[k]    = DIST_W'(p_q[k]) + DIST_W'(integ_q[k]);
      dsh[k]         = DSH_W'(dist_sum[k] >>> 16);
      disturb_new[k] = SAMPLE_W'(clamp(64'(dsh[k]), SAMPLE_W));
      drv_new[k]     = SAMPLE_W'(clamp(64'(dsh[k]) + 64'(volt_q[k]), SAMPLE_W));

      t2[k]      = T2_W'(prod_q[k] >>> 16);
      est_new[k] = EST_W'(clamp(64'(t1_q[k]) + 64'(t2[k]), EST_W));
      est_out[k] = SAMPLE_W'(est_new[k] >>> 8);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      for (int k = 0; k < AXES; k++) begin
        model_gain[k] <= '0;
        decay[k]      <= '0;
        est_q[k]      <= '0;
        integ_q[k]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PROP_GAIN:    prop_gain     <= cfg_data;
          REG_INTEG_GAIN:   integ_gain    <= cfg_data;
          REG_MODEL_GAIN_D: model_gain[0] <= cfg_data;
          REG_MODEL_GAIN_Q: model_gain[1] <= cfg_data;
          REG_DECAY_D:      decay[0]      <= cfg_data[DECAY_W-1:0];
          REG_DECAY_Q:      decay[1]      <= cfg_data[DECAY_W-1:0];
          default: ;
        endcase
      end
      for (int k = 0; k < AXES; k++) begin
        if (op == OP_INTEG) integ_q[k] <= integ_sum[k];
        if (op == OP_EST) est_q[k] <= est_new[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < AXES; k++) begin
      unique case (op)
        OP_LOAD: begin
          e_q[k]    <= e_new[k];
          volt_q[k] <= volt_in[k];
        end
        OP_MUL_P: prod_q[k] <= mul_p[k];
        OP_MUL_I: begin
          p_q[k]    <= prod_sat[k];
          prod_q[k] <= mul_p[k];
        end
        OP_DRIVE: begin
          disturb_q[k] <= disturb_new[k];
          drv_q[k]     <= drv_new[k];
        end
        OP_MUL_M: prod_q[k] <= mul_p[k];
        OP_MUL_D: begin
          t1_q[k]   <= T1_W'(prod_q[k] >>> 8);
          prod_q[k] <= mul_p[k];
        end
        OP_EST: drv_q[k] <= est_out[k];
        default: ;
      endcase
    end
    if (op == OP_OUT) begin
      out_data.est_current_d <= drv_q[0];
      out_data.est_current_q <= drv_q[1];
      out_data.disturb_d     <= disturb_q[0];
      out_data.disturb_q     <= disturb_q[1];
    end
  end

endmodule

### rtl/core/dqco_ctrl.sv
// dqco_ctrl: sequencer for the dq current observer; steps the datapath
// through one item and owns the input and output handshakes. Uses dqco_pkg.
module dqco_ctrl import dqco_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output op_t  op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_I,
    S_INTEG,
    S_DRIVE,
    S_MUL_M,
    S_MUL_D,
    S_EST,
    S_OUT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    op = OP_NONE;
    unique case (state)
      S_IDLE:  op = in_valid ? OP_LOAD : OP_NONE;
      S_MUL_P: op = OP_MUL_P;
      S_MUL_I: op = OP_MUL_I;
      S_INTEG: op = OP_INTEG;
      S_DRIVE: op = OP_DRIVE;
      S_MUL_M: op = OP_MUL_M;
      S_MUL_D: op = OP_MUL_D;
      S_EST:   op = OP_EST;
      S_OUT:   op = out_free ? OP_OUT : OP_NONE;
      default: op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_MUL_P;
        S_MUL_P: state <= S_MUL_I;
        S_MUL_I: state <= S_INTEG;
        S_INTEG: state <= S_DRIVE;
        S_DRIVE: state <= S_MUL_M;
        S_MUL_M: state <= S_MUL_D;
        S_MUL_D: state <= S_EST;
        S_EST:   state <= S_OUT;
        S_OUT:   if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

### rtl/core/dq_current_observer.sv
// dq_current_observer: top level of the closed-loop PI current observer.
// Instantiates dqco_ctrl and dqco_datapath; uses dqco_pkg and assert_macros.svh.
//
//   channel   signals                          width
//   config    cfg_we, cfg_index, cfg_data      3-bit index, 24-bit data
//   input     in_valid, in_ready, in_data      4 x 16-bit samples
//   output    out_valid, out_ready, out_data   4 x 16-bit results
//
// Accepted items go step by step to their result in the output register:
// four products per axis through one 24x25 multiplier per axis, plus accumulate,
// drive and estimate steps. in_ready returns the cycle after the result loads.
// A result waiting on out_ready holds the sequencer in its last step.
// rst is synchronous; it clears config registers, estimates and integrators.
`include "assert_macros.svh"

module dq_current_observer import dqco_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  op_t op;

  dqco_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .op        (op)
  );

  dqco_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .op        (op),
    .out_data  (out_data)
  );

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "in_ready high right after accept")
  `ASSERT_IMPL(a_ready_falls_on_accept, clk, rst, $fell(in_ready), $past(in_valid), "in_ready fell without an item")
  `ASSERT_IMPL(a_result_latency, clk, rst, $rose(out_valid), $past(in_valid && in_ready, 9), "result without matching item")

endmodule

### tb/dq_current_observer_test.sv
`timescale 1ns / 1ps
// dq_current_observer_test: self-checking bench for the dq current observer.
// Predicts each result in a scoreboard class; uses dqco_pkg and the RTL top.

class estimate_scoreboard;
  longint prop_gain, integ_gain;
  longint model_gain[2], decay[2];
  longint est_state[2], integ_state[2];
  dqco_pkg::out_item_t pending_estimates[$];
  int errors, checked;

  function new();
    prop_gain = 0;
    integ_gain = 0;
    errors = 0;
    checked = 0;
    for (int k = 0; k < 2; k++) begin
      model_gain[k] = 0;
      decay[k] = 0;
      est_state[k] = 0;
      integ_state[k] = 0;
    end
  endfunction

  function void write_reg(logic [dqco_pkg::CFG_IDX_W-1:0] idx,
                          logic [dqco_pkg::GAIN_W-1:0] data);
    case (idx)
      dqco_pkg::REG_PROP_GAIN:    prop_gain = longint'(data);
      dqco_pkg::REG_INTEG_GAIN:   integ_gain = longint'(data);
      dqco_pkg::REG_MODEL_GAIN_D: model_gain[0] = longint'(data);
      dqco_pkg::REG_MODEL_GAIN_Q: model_gain[1] = longint'(data);
      dqco_pkg::REG_DECAY_D:      decay[0] = longint'(data[dqco_pkg::DECAY_W-1:0]);
      dqco_pkg::REG_DECAY_Q:      decay[1] = longint'(data[dqco_pkg::DECAY_W-1:0]);
      default: ;
    endcase
  endfunction

  function longint clamp(longint x, int w);
    longint lim;
    lim = longint'(1) << (w - 1);
    if (x > lim - 1) return lim - 1;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function void step_axis(int k, longint meas, longint volt,
                          output longint est_o, output longint dist_o);
    longint est, e, p, inc, dist_sum, drv;
    est = est_state[k];
    e = clamp(meas - (est >>> 8), dqco_pkg::SAMPLE_W);
    p = clamp(e * prop_gain, dqco_pkg::INT_W);
    inc = clamp(e * integ_gain, dqco_pkg::INT_W);
    integ_state[k] = clamp(integ_state[k] + inc, dqco_pkg::INT_W);
    dist_sum = p + integ_state[k];
    dist_o = clamp(dist_sum >>> 16, dqco_pkg::SAMPLE_W);
    drv = clamp((dist_sum + volt * 65536) >>> 16, dqco_pkg::SAMPLE_W);
    est = clamp(((drv * model_gain[k]) >>> 8) + ((est * decay[k]) >>> 16),
                dqco_pkg::EST_W);
    est_state[k] = est;
    est_o = clamp(est >>> 8, dqco_pkg::SAMPLE_W);
  endfunction

  function void note_sample(dqco_pkg::in_item_t it);
    longint ed, eq, dd, dq;
    dqco_pkg::out_item_t r;
    step_axis(0, longint'($signed(it.meas_current_d)), longint'($signed(it.volt_cmd_d)),
              ed, dd);
    step_axis(1, longint'($signed(it.meas_current_q)), longint'($signed(it.volt_cmd_q)),
              eq, dq);
    r.est_current_d = ed[dqco_pkg::SAMPLE_W-1:0];
    r.est_current_q = eq[dqco_pkg::SAMPLE_W-1:0];
    r.disturb_d = dd[dqco_pkg::SAMPLE_W-1:0];
    r.disturb_q = dq[dqco_pkg::SAMPLE_W-1:0];
    pending_estimates.push_back(r);
  endfunction

  function void compare_field(string name, logic [dqco_pkg::SAMPLE_W-1:0] want,
                              logic [dqco_pkg::SAMPLE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
      errors++;
    end
  endfunction

  function void check_estimate(dqco_pkg::out_item_t got);
    dqco_pkg::out_item_t want;
    if (pending_estimates.size() == 0) begin
      $error("result item with none outstanding: %h", got);
      errors++;
      return;
    end
    want = pending_estimates.pop_front();
    checked++;
    compare_field("est_current_d", want.est_current_d, got.est_current_d);
    compare_field("est_current_q", want.est_current_q, got.est_current_q);
    compare_field("disturb_d", want.disturb_d, got.disturb_d);
    compare_field("disturb_q", want.disturb_q, got.disturb_q);
  endfunction

  function int pending();
    return pending_estimates.size();
  endfunction
endclass

module dq_current_observer_test;
  import dqco_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(7);
  localparam int SETTLE = 12;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 155;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;

  estimate_scoreboard sb;
  bit no_idle;
  int hold_seq, hold_len, hold_ack, hold_left;
  int items_sent, settings;

  dq_current_observer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // receiver: random back-pressure plus requested long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seq != hold_ack) begin
      hold_ack <= hold_seq;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 29);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_estimate(out_data);
  end

  task automatic send_item(in_item_t it);
    while (!no_idle && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(it);
    items_sent++;
  endtask

  task automatic send_fields(logic [SAMPLE_W-1:0] md, logic [SAMPLE_W-1:0] mq,
                             logic [SAMPLE_W-1:0] vd, logic [SAMPLE_W-1:0] vq);
    in_item_t it;
    it.meas_current_d = md;
    it.meas_current_q = mq;
    it.volt_cmd_d = vd;
    it.volt_cmd_q = vq;
    send_item(it);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // decay values may carry junk above bit 15; unused indexes are hit every time
  task automatic apply_config(logic [GAIN_W-1:0] pg, logic [GAIN_W-1:0] ig,
                              logic [GAIN_W-1:0] mgd, logic [GAIN_W-1:0] mgq,
                              logic [GAIN_W-1:0] dcd, logic [GAIN_W-1:0] dcq);
    cfg_write(REG_PROP_GAIN, pg);
    cfg_write(REG_INTEG_GAIN, ig);
    cfg_write(REG_MODEL_GAIN_D, mgd);
    cfg_write(REG_MODEL_GAIN_Q, mgq);
    cfg_write(REG_DECAY_D, dcd);
    cfg_write(REG_DECAY_Q, dcq);
    cfg_write(REG_UNUSED_LO, GAIN_W'($urandom));
    cfg_write(REG_UNUSED_HI, GAIN_W'($urandom));
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return GAIN_W'($urandom_range(0, 24'h01FFFF));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_decay();
    logic [DECAY_W-1:0] d;
    case ($urandom_range(0, 4))
      0: d = '0;
      1: d = '1;
      2, 3: d = DECAY_W'($urandom_range(16'hC000, 16'hFFFF));
      default: d = DECAY_W'($urandom);
    endcase
    return {8'($urandom), d};
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return SAMPLE_W'($urandom_range(0, 1023)) - SAMPLE_W'(512);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] near(logic [SAMPLE_W-1:0] base);
    return base + SAMPLE_W'($urandom_range(0, 64)) - SAMPLE_W'(32);
  endfunction

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [SAMPLE_W-1:0] bmd, bmq, bvd, bvq;
    bit smooth;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    no_idle = 1'b0;
    hold_seq = 0;
    hold_len = 0;
    hold_ack = 0;
    hold_left = 0;
    items_sent = 0;
    settings = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: all gains zero
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_fields(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_fields(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    drain();

    // full-scale gains: saturation at every stage
    apply_config('1, '1, '1, '1, 24'hA5FFFF, 24'h5AFFFF);
    send_fields(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_fields(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_fields(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_fields(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_fields(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_fields(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
    drain();

    // typical motor values
    apply_config(24'h008000, 24'h000010, 24'h00609D, 24'h004000, 24'hFFE666, 24'h00F000);
    send_fields(16'h0100, 16'hFF00, 16'h0C00, 16'hF400);
    send_fields(16'h0100, 16'hFF00, 16'h0C00, 16'hF400);
    send_fields(16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
    send_fields(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_fields(16'h0001, 16'h0001, 16'h0001, 16'h0001);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      smooth = (phase % 2 == 0);
      if (phase == 0)
        apply_config('1, '1, '1, '1, pick_decay() | 24'h00FFFF, pick_decay() | 24'h00FFFF);
      else if (phase == 1)
        apply_config('0, '0, '0, '0, pick_decay() & 24'hFF0000, pick_decay() & 24'hFF0000);
      else if (smooth)
        apply_config(GAIN_W'($urandom_range(0, 24'h020000)), GAIN_W'($urandom_range(0, 1024)),
                     GAIN_W'($urandom_range(0, 24'h010000)),
                     GAIN_W'($urandom_range(0, 24'h010000)),
                     {8'($urandom), 16'($urandom_range(16'hC000, 16'hFFFF))},
                     {8'($urandom), 16'($urandom_range(16'hC000, 16'hFFFF))});
      else
        apply_config(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_decay(),
                     pick_decay());
      no_idle = (phase == 3);
      bmd = pick_sample();
      bmq = pick_sample();
      bvd = pick_sample();
      bvq = pick_sample();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((phase == 5 || phase == 9) && n == 20) begin
          hold_len <= 300;
          hold_seq <= hold_seq + 1;
        end
        if (smooth && $urandom_range(0, 9) != 0) begin
          bmd = near(bmd);
          bmq = near(bmq);
          bvd = near(bvd);
          bvq = near(bvq);
          send_fields(near(bmd), near(bmq), bvd, bvq);
        end else begin
          send_fields(pick_sample(), pick_sample(), pick_sample(), pick_sample());
        end
      end
      drain();
    end

    $display("%0d samples under %0d gain settings (reset, zero, full scale, random, typical)",
             items_sent, settings);
    $display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/dqco_pkg.sv
rtl/core/dqco_datapath.sv
rtl/core/dqco_ctrl.sv
rtl/core/dq_current_observer.sv
tb/dq_current_observer_test.sv
